// File: hdl/esc_tsc_pkg.sv
`default_nettype none

package esc_tsc_pkg;

	localparam int SLOT_COUNT = 12;
	localparam int SLOT_AW = $clog2(SLOT_COUNT);
	localparam int TS_W = 16;
	localparam int IDX_W = 4;

	localparam logic [TS_W-1:0] TICKS_PER_MS_RESET = 16'd2000;

	localparam int CAL_SLOT_HALF = 0;
	localparam int CAL_SLOT_A = 9;
	localparam int CAL_SLOT_B = 10;

	localparam logic [1:0] MODE_RISE = 2'd0;
	localparam logic [1:0] MODE_FALL = 2'd1;
	localparam logic [1:0] MODE_TELEM = 2'd2;
	localparam logic [1:0] MODE_WINDOW = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [TS_W-1:0] timestamp;
	} ev_t;

	typedef struct packed {
		logic [TS_W-1:0] pulse_width;
		logic [IDX_W-1:0] slot_index;
		logic [TS_W-1:0] slot_value;
		logic slot_written;
		logic [TS_W-1:0] ticks_per_ms;
		logic frame_restart;
		logic data_updated;
	} res_t;

endpackage

`default_nettype wire

// File: hdl/esc_tsc_state.sv
`default_nettype none

module esc_tsc_state (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire esc_tsc_pkg::ev_t ev,
	output esc_tsc_pkg::res_t res
);
	import esc_tsc_pkg::*;

	logic [TS_W-1:0] rise_q;
	logic [TS_W-1:0] width_q;
	logic [TS_W-1:0] slot_q [SLOT_COUNT];
	logic [SLOT_AW-1:0] ptr_q;
	logic got_q;
	logic [TS_W-1:0] cal_q;
	logic new_q;

	logic [TS_W-1:0] rise_d;
	logic [TS_W-1:0] width_d;
	logic [SLOT_AW-1:0] ptr_d;
	logic got_d;
	logic [TS_W-1:0] cal_d;
	logic new_d;
	logic wr;
	logic [TS_W-1:0] wr_val;
	logic restart;
	logic [TS_W-1:0] min_ab;

	assign min_ab = (slot_q[CAL_SLOT_A] < slot_q[CAL_SLOT_B]) ?
		slot_q[CAL_SLOT_A] : slot_q[CAL_SLOT_B];

	always_comb begin
		rise_d = rise_q;
		width_d = width_q;
		ptr_d = ptr_q;
		got_d = got_q;
		cal_d = cal_q;
		new_d = new_q;
		wr = 1'b0;
		wr_val = '0;
		restart = 1'b0;
		case (ev.mode)
			MODE_RISE: begin
				rise_d = ev.timestamp;
			end
			MODE_FALL: begin
				width_d = ev.timestamp - rise_q;
			end
			MODE_TELEM: begin
				// The pointer never passes the last slot, so every telemetry edge writes.
				wr = 1'b1;
				wr_val = ev.timestamp - width_q;
				if (ptr_q < SLOT_AW'(SLOT_COUNT - 1)) begin
					ptr_d = ptr_q + SLOT_AW'(1);
					got_d = 1'b1;
					new_d = 1'b1;
				end
			end
			MODE_WINDOW: begin
				if (!got_q) begin
					cal_d = {1'b0, slot_q[CAL_SLOT_HALF][TS_W-1:1]} + min_ab;
					ptr_d = '0;
					restart = 1'b1;
				end
				got_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= '0;
			width_q <= '0;
			ptr_q <= '0;
			got_q <= 1'b0;
			cal_q <= TICKS_PER_MS_RESET;
			new_q <= 1'b1;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= '0;
			end
		end else if (en) begin
			rise_q <= rise_d;
			width_q <= width_d;
			ptr_q <= ptr_d;
			got_q <= got_d;
			cal_q <= cal_d;
			new_q <= new_d;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (wr && ptr_q == SLOT_AW'(i)) begin
					slot_q[i] <= wr_val;
				end
			end
		end
	end

	always_comb begin
		res.pulse_width = width_d;
		res.slot_index = wr ? IDX_W'(ptr_q) : '0;
		res.slot_value = wr_val;
		res.slot_written = wr;
		res.ticks_per_ms = cal_d;
		res.frame_restart = restart;
		res.data_updated = new_d;
	end

endmodule

`default_nettype wire

// File: hdl/esc_telemetry_slot_capture.sv
// An accepted request is registered in ev_s1, and its result is registered in res_s2.
// Throughput: one request per cycle while the output is not stalled; a stalled result holds both stages.
// All work for a request is one pass through the state update logic.
// Reset clears the handshake state and loads the capture state with its
// power-on values; no clearing pass is needed.
`default_nettype none

module esc_telemetry_slot_capture (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] mode,
	input wire logic [15:0] timestamp,
	output logic out_valid,
	input wire logic out_ready,
	output logic [15:0] pulse_width,
	output logic [3:0] slot_index,
	output logic [15:0] slot_value,
	output logic slot_written,
	output logic [15:0] ticks_per_ms,
	output logic frame_restart,
	output logic data_updated
);
	import esc_tsc_pkg::*;

	ev_t ev_s1;
	logic valid_s1;
	res_t res_s2;
	logic valid_s2;
	res_t res_next;
	logic adv;

	assign adv = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ev_s1.mode <= mode;
			ev_s1.timestamp <= timestamp;
		end
	end

	esc_tsc_state u_state (
		.clk(clk),
		.arst_n(arst_n),
		.en(valid_s1 && adv),
		.ev(ev_s1),
		.res(res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid = valid_s2;
	assign pulse_width = res_s2.pulse_width;
	assign slot_index = res_s2.slot_index;
	assign slot_value = res_s2.slot_value;
	assign slot_written = res_s2.slot_written;
	assign ticks_per_ms = res_s2.ticks_per_ms;
	assign frame_restart = res_s2.frame_restart;
	assign data_updated = res_s2.data_updated;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.slot_written |-> res_s2.slot_index < IDX_W'(SLOT_COUNT))
		else $error("slot index beyond the last slot");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.slot_written && res_s2.frame_restart))
		else $error("slot write and frame restart in one result");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.data_updated)
		else $error("new data flag dropped");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("request refused while the result stage is empty");

endmodule

`default_nettype wire
